// ----- rtl/fnvb_pkg.sv -----
// ============================================================================
// fnvb_pkg
// types, constants and the byte mix function of the fnv-1a bucket index unit
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fnvb_pkg;

    localparam int HASH_W     = 64;
    localparam int BYTE_W     = 8;
    localparam int SIZE_W     = 32;
    localparam int IDX_W      = 32;
    localparam int INDEX_BITS = 32;
    localparam int STEP_W     = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 32'd1024;

    localparam logic [IDX_W-1:0] IDX_MASK = (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} :
        IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

    typedef logic [HASH_W-1:0] hash_t;

    typedef struct packed {
        logic  valid;
        hash_t hash;
    } hash_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // prime is 2^40 + 0x1b3, so the product is a handful of shifted adds
    function automatic hash_t fnv_mix(input hash_t h, input logic [BYTE_W-1:0] b);
        hash_t x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fnvb_ifs.sv -----
// ============================================================================
// fnvb channel interfaces
// valid/ready channels for key bytes, results and the table size write
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface fnvb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       key_empty;

    modport source (output valid, data_byte, last_byte, key_empty, input ready);
    modport sink   (input valid, data_byte, last_byte, key_empty, output ready);
endinterface

interface fnvb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic [31:0] bucket_index;

    modport source (output valid, hash_value, bucket_index, input ready);
    modport sink   (input valid, hash_value, bucket_index, output ready);
endinterface

interface fnvb_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] table_size;

    modport source (output valid, table_size, input ready);
    modport sink   (input valid, table_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/fnvb_front.sv -----
// ============================================================================
// fnvb_front
// takes key bytes, keeps the running hash and pushes the hash at key end
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fnvb_front
    import fnvb_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    fnvb_in_if.sink         key_in,
    input  q_stat_t         q_stat,
    output hash_push_t      push
);

    hash_t hash_reg;
    hash_t hash_next;
    hash_t mixed;
    logic  accept;
    logic  key_done;

    assign key_in.ready = !q_stat.full;
    assign accept       = key_in.valid && key_in.ready;
    assign mixed        = fnv_mix(hash_reg, key_in.data_byte);
    assign key_done     = key_in.key_empty || key_in.last_byte;

    assign push.valid = accept && key_done;
    assign push.hash  = key_in.key_empty ? hash_reg : mixed;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            if (key_done)
            begin
                hash_next = FNV_BASIS;
            end
            else
            begin
                hash_next = mixed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fnvb_queue.sv -----
// ============================================================================
// fnvb_queue
// two-entry queue of finished key hashes between front and back
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fnvb_queue
    import fnvb_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  hash_push_t push,
    input  logic       pop,
    output q_stat_t    q_stat,
    output hash_t      rd_hash
);

    hash_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign rd_hash      = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.hash;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fnvb_back.sv -----
// ============================================================================
// fnvb_back
// bit-serial remainder of the hash by the table size, result register
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fnvb_back
    import fnvb_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  q_stat_t           q_stat,
    input  hash_t             rd_hash,
    input  logic [SIZE_W-1:0] table_size,
    output logic              pop,
    fnvb_out_if.source        result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    hash_t             hash_reg;
    hash_t             dvd_reg;
    logic [SIZE_W-1:0] div_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;
    logic [SIZE_W:0]   rem_shift;
    logic [SIZE_W:0]   diff;

    assign rem_shift = {rem_reg, dvd_reg[HASH_W-1]};
    assign diff      = rem_shift - {1'b0, div_reg};
    assign rem_next  = diff[SIZE_W] ? rem_shift[SIZE_W-1:0] : diff[SIZE_W-1:0];

    assign pop                 = (state_reg == ST_IDLE) && !q_stat.empty;
    assign result.valid        = (state_reg == ST_OUT);
    assign result.hash_value   = hash_reg;
    assign result.bucket_index = (div_reg == '0) ? '0 : (rem_reg & IDX_MASK);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(HASH_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hash_reg <= rd_hash;
            dvd_reg  <= rd_hash;
            div_reg  <= table_size;
            rem_reg  <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            dvd_reg <= {dvd_reg[HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fnv1a_bucket_index_unit.sv -----
// ============================================================================
// fnv1a_bucket_index_unit
// 64-bit fnv-1a key hash with bucket index, key taken one byte per beat
// ============================================================================
// path: the hash of a finished key goes through the hash queue and the remainder unit to the result
// throughput: one key byte per cycle into the hasher while the hash queue is not full
// each key runs through the one-bit-per-cycle remainder unit, which takes no new hash
// until its result beat is taken; a two-entry hash queue lets bytes of later keys go on meanwhile
// reset: running hash to the offset basis, table size to 1024, queue empty
`timescale 1ns / 1ps
`default_nettype none

module fnv1a_bucket_index_unit
    import fnvb_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    fnvb_cfg_if.sink    cfg,
    fnvb_in_if.sink     key_in,
    fnvb_out_if.source  result
);

    logic [SIZE_W-1:0] table_size_reg;
    hash_push_t        push;
    q_stat_t           q_stat;
    hash_t             rd_hash;
    logic              pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            table_size_reg <= cfg.table_size;
        end
    end

    fnvb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_in (key_in),
        .q_stat (q_stat),
        .push   (push)
    );

    fnvb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .q_stat  (q_stat),
        .rd_hash (rd_hash)
    );

    fnvb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .rd_hash    (rd_hash),
        .table_size (table_size_reg),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

// ----- rtl/fnvb_checker.sv -----
// ============================================================================
// fnvb_checker
// port-level checks of the fnv-1a bucket index unit, bound to the top level
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fnvb_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        cfg_valid,
    input wire        cfg_ready,
    input wire [31:0] cfg_size,
    input wire        in_valid,
    input wire        in_ready,
    input wire        in_last,
    input wire        in_empty,
    input wire        out_valid,
    input wire        out_ready,
    input wire [63:0] out_hash,
    input wire [31:0] out_index
);

    logic [31:0] size_reg;
    logic [2:0]  pend_reg;
    logic [2:0]  pend_next;
    logic        key_end;
    logic        res_beat;

    assign key_end  = in_valid && in_ready && (in_last || in_empty);
    assign res_beat = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (key_end && !res_beat)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (res_beat && !key_end)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 32'd1024;
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_size;
            end
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_hash) && $stable(out_index))
        else $error("result changed while stalled");

    // index within the table
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((size_reg == 32'd0) ? (out_index == 32'd0) : (out_index < size_reg)))
        else $error("bucket index out of range");

    // no result without a finished key
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("result beat without a pending key");

    // at most queue plus back end in flight
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3)
        else $error("too many keys in flight");

endmodule

bind fnv1a_bucket_index_unit fnvb_checker u_fnvb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_size  (cfg.table_size),
    .in_valid  (key_in.valid),
    .in_ready  (key_in.ready),
    .in_last   (key_in.last_byte),
    .in_empty  (key_in.key_empty),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_hash  (result.hash_value),
    .out_index (result.bucket_index)
);

`default_nettype wire

// ----- bench/tb_fnv1a_bucket_index_unit.sv -----
// ============================================================================
// tb_fnv1a_bucket_index_unit
// Feeds keys one byte per beat and checks each hash and bucket index result.
// A directed table runs first: the empty key, "a", "foobar", the empty flag in
// the middle of a key, and both flags together. Random keys follow under
// several table sizes, including zero, one and the largest value. A local
// model of the running hash predicts every result, and results are compared
// in order. Both sides idle or stall at random, depending on the phase.
// ============================================================================
`timescale 1ns / 1ps

module tb_fnv1a_bucket_index_unit;
    import fnvb_pkg::*;

    localparam logic [63:0] HASH_BASIS  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] HASH_PRIME  = 64'd1099511628211;
    localparam logic [31:0] SIZE_AT_RST = 32'd1024;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          END_CYCLES   = 150;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          REPORT_MAX   = 10;

    typedef struct packed {
        logic [63:0] hash;
        logic [31:0] bucket;
    } hash_result_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         empty;
        logic         has_known;
        hash_result_t known;
    } stim_row_t;

    localparam hash_result_t NO_RES = '{64'd0, 32'd0};

    logic clk;
    logic rst_n;

    fnvb_cfg_if cfg_bus ();
    fnvb_in_if  key_bus ();
    fnvb_out_if res_bus ();

    fnv1a_bucket_index_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .key_in (key_bus),
        .result (res_bus)
    );

    logic [63:0]  running_hash_q = HASH_BASIS;
    logic [31:0]  table_size_q   = SIZE_AT_RST;
    hash_result_t pending_results [$];
    int           mismatches     = 0;
    int           quiet_cycles   = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;

    stim_row_t directed_rows [20] = '{
        '{8'hA5, 1'b0, 1'b1, 1'b1, '{HASH_BASIS, 32'd805}},
        '{8'h61, 1'b1, 1'b0, 1'b1, '{64'hAF63_DC4C_8601_EC8C, 32'd140}},
        '{8'h66, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h6F, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h6F, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h62, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h61, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h72, 1'b1, 1'b0, 1'b1, '{64'h8594_4171_F739_67E8, 32'd1000}},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h12, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h34, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h56, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'h7E, 1'b1, 1'b1, 1'b1, '{HASH_BASIS, 32'd805}},
        '{8'h80, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hFE, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hAB, 1'b1, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b1, 1'b1, '{HASH_BASIS, 32'd805}}
    };

    function automatic logic [63:0] mix_key_byte(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x * HASH_PRIME;
    endfunction

    function automatic logic [31:0] bucket_of_hash(input logic [63:0] h);
        logic [63:0] mask;
        logic [63:0] rem;
        if (table_size_q == 32'd0)
            return 32'd0;
        mask = (INDEX_BITS >= 64) ? {64{1'b1}} : ((64'd1 << INDEX_BITS) - 64'd1);
        rem  = h % {32'd0, table_size_q};
        return rem[31:0] & mask[31:0];
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one key beat, then the hash model advances on acceptance
    task automatic send_beat(input logic [7:0] b, input logic l, input logic e,
                             input logic has_known, input hash_result_t known);
        hash_result_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            key_bus.valid <= 1'b0;
            @(posedge clk);
        end
        key_bus.valid     <= 1'b1;
        key_bus.data_byte <= b;
        key_bus.last_byte <= l;
        key_bus.key_empty <= e;
        do @(posedge clk); while (!key_bus.ready);
        if (!e)
            running_hash_q = mix_key_byte(running_hash_q, b);
        if (e || l)
        begin
            res.hash   = running_hash_q;
            res.bucket = bucket_of_hash(running_hash_q);
            pending_results.push_back(has_known ? known : res);
            running_hash_q = HASH_BASIS;
        end
    endtask

    task automatic hold_until_drained();
        key_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_table_size(input logic [31:0] size);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.table_size <= size;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        table_size_q = size;
    endtask

    task automatic run_keys(input int n_beats);
        int sent;
        int kind;
        int len;
        int keys;
        sent = 0;
        keys = 0;
        while (sent < n_beats)
        begin
            kind = $urandom_range(99);
            if (kind < 8)
            begin
                send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b0,
                          NO_RES);
                sent++;
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 6);
                for (int i = 0; i < len - 1; i++)
                    send_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_RES);
                if (kind < 16)
                    send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b0,
                              NO_RES);
                else
                    send_beat(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, NO_RES);
                sent += len;
            end
            keys++;
            if (keys == 1 || $urandom_range(29) == 0)
                hold_until_drained();
        end
    endtask

    task automatic run_phase(input logic [31:0] size, input int src_pct, input int sink_pct,
                             input int n_beats);
        write_table_size(size);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        run_keys(n_beats);
    endtask

    // result side: random stalls and in-order compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin : check_beat
                hash_result_t want;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: hash %h bucket %0d",
                                 res_bus.hash_value, res_bus.bucket_index);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_bus.hash_value !== want.hash || res_bus.bucket_index !== want.bucket)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch: hash exp %h got %h, bucket exp %0d got %0d",
                                     want.hash, res_bus.hash_value,
                                     want.bucket, res_bus.bucket_index);
                    end
                end
            end
            res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog on cycles with no beat anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((key_bus.valid && key_bus.ready) || (res_bus.valid && res_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        key_bus.valid      <= 1'b0;
        key_bus.data_byte  <= 8'd0;
        key_bus.last_byte  <= 1'b0;
        key_bus.key_empty  <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.table_size <= 32'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].data, directed_rows[i].last, directed_rows[i].empty,
                      directed_rows[i].has_known, directed_rows[i].known);

        run_phase(32'd1,                  0,  0, 150);
        run_phase(32'hFFFF_FFFF,         81,  0, 150);
        run_phase(32'd0,                  0, 81, 150);
        run_phase(32'd1000003,           20, 20, 150);
        run_phase(32'h8000_0000,          0,  0, 150);
        run_phase($urandom,              81,  0, 100);
        run_phase($urandom_range(2, 64),  0, 81, 150);
        run_phase(SIZE_AT_RST,           20, 20, 150);

        hold_until_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
